/* src/tpu_pkg.sv */
// Shared types, constants and helpers for the packed pattern unpacker.
// Used by tpu_front, tpu_back and tracker_pattern_unpacker_core; no dependencies.
package tpu_pkg;

  // Parse phase of the byte-level parser.
  typedef enum logic [2:0] {
    PH_CHAN = 3'd0,
    PH_MASK = 3'd1,
    PH_NOTE = 3'd2,
    PH_INS  = 3'd3,
    PH_VOL  = 3'd4,
    PH_CMD  = 3'd5,
    PH_ARG  = 3'd6
  } phase_e;

  // One row of channel memory: the mask and the last values of a channel.
  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] note;
    logic [7:0] ins;
    logic [7:0] vol;
    logic [7:0] cmd;
    logic [7:0] arg;
  } chan_rec_t;

  localparam logic [7:0] VOL_RESET = 8'hFF;
  localparam chan_rec_t REC_RESET = '{
    mask: 8'h00, note: 8'h00, ins: 8'h00, vol: VOL_RESET, cmd: 8'h00, arg: 8'h00
  };

  // One packed byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic       entry_valid;
    logic [7:0] row;
    logic [5:0] channel;
    logic [7:0] note;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] command;
    logic [7:0] command_arg;
    logic [3:0] field_mask;
    logic       pattern_done;
  } result_t;

  // Outcome of looking for the next field that a mask asks for.
  typedef struct packed {
    logic   emit;
    phase_e phase;
  } adv_t;

  // Configuration register indexes and reset values.
  localparam logic [0:0] REG_PATTERN_ROWS = 1'b0;
  localparam logic [7:0] ROWS_RESET       = 8'd64;

  // First field phase at or after from_ph whose mask bit is set, or emit.
  function automatic adv_t adv_phase(input phase_e from_ph, input logic [3:0] m);
    adv_t r;
    r.emit  = 1'b0;
    r.phase = PH_CHAN;
    if (from_ph <= PH_NOTE && m[0]) begin
      r.phase = PH_NOTE;
    end else if (from_ph <= PH_INS && m[1]) begin
      r.phase = PH_INS;
    end else if (from_ph <= PH_VOL && m[2]) begin
      r.phase = PH_VOL;
    end else if (m[3]) begin
      r.phase = PH_CMD;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

endpackage

/* src/tracker_pattern_unpacker_core.sv */
// A byte passes the front queue, the execute stage and the output register.
// Throughput: one byte per cycle while output is not stalled; the parse step has one
// channel memory read (registered, with the current channel forwarded) per byte.
// Reset: parser and pattern_rows (64) return to their reset values at once; the
// channel memory needs no clearing pass, since a valid bit per channel row makes
// an unwritten row read as its reset value.
module tracker_pattern_unpacker_core #(
  parameter int unsigned CHANNELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Packed byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  packed_byte_i,
  input  logic        pattern_start_i,
  // Cell record output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        entry_valid_o,
  output logic [7:0]  row_o,
  output logic [5:0]  channel_o,
  output logic [7:0]  note_o,
  output logic [7:0]  instrument_o,
  output logic [7:0]  volume_o,
  output logic [7:0]  command_o,
  output logic [7:0]  command_arg_o,
  output logic [3:0]  field_mask_o,
  output logic        pattern_done_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0]       pattern_rows_q;
  logic             cfg_write;
  logic             head_valid, head_pop;
  tpu_pkg::item_t   head_item;
  logic [CW-1:0]    head_chan;
  tpu_pkg::result_t res;

  // The configuration port never waits. The single register sits at byte
  // address zero; paddr[2] picks the register index.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_rows_q <= tpu_pkg::ROWS_RESET;
    end else if (cfg_write && paddr[2:2] == tpu_pkg::REG_PATTERN_ROWS) begin
      pattern_rows_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2:2] == tpu_pkg::REG_PATTERN_ROWS) begin
      prdata = {24'd0, pattern_rows_q};
    end
  end

  // The front takes one transaction per cycle into a short queue unless it is full,
  // and resolves the channel index a channel byte would select, so the back can start its
  // channel memory read as the byte leaves the queue.
  tpu_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .packed_byte_i  (packed_byte_i),
    .pattern_start_i(pattern_start_i),
    .head_valid_o   (head_valid),
    .head_item_o    (head_item),
    .head_chan_o    (head_chan),
    .head_pop_i     (head_pop)
  );

  // The back parses one byte per cycle, updates the channel memory and holds
  // each result in an output register; it only waits when that register is
  // full and not being taken, while the queue absorbs input until it is full.
  tpu_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pattern_rows_i(pattern_rows_q),
    .head_valid_i  (head_valid),
    .head_item_i   (head_item),
    .head_chan_i   (head_chan),
    .head_pop_o    (head_pop),
    .res_valid_o   (out_valid_o),
    .res_o         (res),
    .res_stall_i   (out_stall_i)
  );

  assign entry_valid_o  = res.entry_valid;
  assign row_o          = res.row;
  assign channel_o      = res.channel;
  assign note_o         = res.note;
  assign instrument_o   = res.instrument;
  assign volume_o       = res.volume;
  assign command_o      = res.command;
  assign command_arg_o  = res.command_arg;
  assign field_mask_o   = res.field_mask;
  assign pattern_done_o = res.pattern_done;

endmodule

/* src/tpu_front.sv */
// Front end of the unpacker: accepts packed bytes, works out the channel index
// and holds them in a two-entry queue. Depends on tpu_pkg.
module tpu_front #(
  parameter int unsigned CHANNELS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            packed_byte_i,
  input  logic                  pattern_start_i,
  output logic                  head_valid_o,
  output tpu_pkg::item_t        head_item_o,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] head_chan_o,
  input  logic                  head_pop_i
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CW-1:0]  chan_lut [64];
  logic [5:0]     chan_raw;
  tpu_pkg::item_t item_q [2];
  logic [CW-1:0]  chan_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push, pop;

  // Channel byte b selects ((b - 1) mod 64) mod CHANNELS.
  for (genvar gi = 0; gi < 64; gi++) begin : g_lut
    assign chan_lut[gi] = CW'(gi % CHANNELS);
  end

  assign chan_raw     = packed_byte_i[5:0] - 6'd1;
  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != 2'd0);
  assign pop          = head_pop_i && head_valid_o;
  assign head_item_o  = item_q[rd_ptr_q];
  assign head_chan_o  = chan_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      item_q[wr_ptr_q] <= '{data: packed_byte_i, start: pattern_start_i};
      chan_q[wr_ptr_q] <= chan_lut[chan_raw];
    end
  end

endmodule

/* src/tpu_back.sv */
// Back end of the unpacker: parser state, channel memory and the result register.
// Depends on tpu_pkg; fed by tpu_front.
module tpu_back #(
  parameter int unsigned CHANNELS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            pattern_rows_i,
  input  logic                  head_valid_i,
  input  tpu_pkg::item_t        head_item_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] head_chan_i,
  output logic                  head_pop_o,
  output logic                  res_valid_o,
  output tpu_pkg::result_t      res_o,
  input  logic                  res_stall_i
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Execute stage and the channel memory read that goes with it.
  logic                a_valid_q;
  tpu_pkg::item_t      a_item_q;
  logic [CW-1:0]       a_chan_q;
  tpu_pkg::chan_rec_t  rd_q;
  tpu_pkg::chan_rec_t  mem_q [CHANNELS];
  logic [CHANNELS-1:0] valid_q;

  // Parser state; work_q mirrors the memory row of the current channel.
  tpu_pkg::phase_e     phase_q, phase_d, phase_eff;
  logic [7:0]          row_q, row_d, row_eff;
  logic [CW-1:0]       cur_q, cur_d, cur_eff;
  logic                done_q, done_d, done_eff;
  tpu_pkg::chan_rec_t  work_q, work_d, work_eff, lookup;

  tpu_pkg::adv_t       adv_r;
  logic                do_adv, emit, marker, mem_we, res_valid;
  logic [3:0]          fm;
  logic [7:0]          b;
  logic                fire, load_a, out_free;
  tpu_pkg::result_t    res_d, out_q;
  logic                out_valid_q;

  assign b          = a_item_q.data;
  assign out_free   = !out_valid_q || !res_stall_i;
  assign fire       = a_valid_q && (!res_valid || out_free);
  assign load_a     = !a_valid_q || fire;
  assign head_pop_o = load_a && head_valid_i;

  // A start byte clears the pattern before it is parsed.
  always_comb begin
    phase_eff = a_item_q.start ? tpu_pkg::PH_CHAN : phase_q;
    row_eff   = a_item_q.start ? 8'd0 : row_q;
    cur_eff   = a_item_q.start ? '0 : cur_q;
    done_eff  = a_item_q.start ? 1'b0 : done_q;
    work_eff  = a_item_q.start ? tpu_pkg::REC_RESET : work_q;
    // The row written at the edge of the read is always the current channel's,
    // so work_q forwards it; a row never written reads as the reset row.
    if (a_item_q.start || !valid_q[a_chan_q]) begin
      lookup = tpu_pkg::REC_RESET;
    end else if (a_chan_q == cur_q) begin
      lookup = work_q;
    end else begin
      lookup = rd_q;
    end
  end

  always_comb begin
    phase_d = phase_eff;
    row_d   = row_eff;
    cur_d   = cur_eff;
    done_d  = done_eff;
    work_d  = work_eff;
    mem_we  = 1'b0;
    emit    = 1'b0;
    marker  = 1'b0;
    do_adv  = 1'b0;
    adv_r   = '{emit: 1'b0, phase: tpu_pkg::PH_CHAN};
    if (!done_eff) begin
      unique case (phase_eff)
        tpu_pkg::PH_MASK: begin
          work_d.mask = b;
          mem_we      = 1'b1;
          do_adv      = 1'b1;
          adv_r       = tpu_pkg::adv_phase(tpu_pkg::PH_NOTE, b[3:0]);
        end
        tpu_pkg::PH_NOTE: begin
          work_d.note = b;
          mem_we      = 1'b1;
          do_adv      = 1'b1;
          adv_r       = tpu_pkg::adv_phase(tpu_pkg::PH_INS, work_eff.mask[3:0]);
        end
        tpu_pkg::PH_INS: begin
          work_d.ins = b;
          mem_we     = 1'b1;
          do_adv     = 1'b1;
          adv_r      = tpu_pkg::adv_phase(tpu_pkg::PH_VOL, work_eff.mask[3:0]);
        end
        tpu_pkg::PH_VOL: begin
          work_d.vol = b;
          mem_we     = 1'b1;
          do_adv     = 1'b1;
          adv_r      = tpu_pkg::adv_phase(tpu_pkg::PH_CMD, work_eff.mask[3:0]);
        end
        tpu_pkg::PH_CMD: begin
          work_d.cmd = b;
          mem_we     = 1'b1;
          phase_d    = tpu_pkg::PH_ARG;
        end
        tpu_pkg::PH_ARG: begin
          work_d.arg = b;
          mem_we     = 1'b1;
          emit       = 1'b1;
          phase_d    = tpu_pkg::PH_CHAN;
        end
        default: begin
          // Channel byte expected.
          phase_d = tpu_pkg::PH_CHAN;
          if (row_eff >= pattern_rows_i) begin
            done_d = 1'b1;
          end else if (b == 8'd0) begin
            row_d = row_eff + 8'd1;
            if (row_d >= pattern_rows_i) begin
              done_d = 1'b1;
              marker = 1'b1;
            end
          end else begin
            cur_d  = a_chan_q;
            work_d = lookup;
            if (b[7]) begin
              phase_d = tpu_pkg::PH_MASK;
            end else begin
              do_adv = 1'b1;
              adv_r  = tpu_pkg::adv_phase(tpu_pkg::PH_NOTE, lookup.mask[3:0]);
            end
          end
        end
      endcase
      if (do_adv) begin
        if (adv_r.emit) begin
          emit    = 1'b1;
          phase_d = tpu_pkg::PH_CHAN;
        end else begin
          phase_d = adv_r.phase;
        end
      end
    end
  end

  // Result record: a cell when an entry completes, else the end marker.
  always_comb begin
    fm        = work_d.mask[3:0] | work_d.mask[7:4];
    res_valid = emit || marker;
    res_d     = '0;
    res_d.row = row_eff;
    if (emit) begin
      res_d.entry_valid = 1'b1;
      res_d.channel     = 6'(cur_d);
      res_d.note        = fm[0] ? work_d.note : 8'd0;
      res_d.instrument  = fm[1] ? work_d.ins : 8'd0;
      res_d.volume      = fm[2] ? work_d.vol : 8'd0;
      res_d.command     = fm[3] ? work_d.cmd : 8'd0;
      res_d.command_arg = fm[3] ? work_d.arg : 8'd0;
      res_d.field_mask  = fm;
    end else begin
      res_d.pattern_done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      phase_q     <= tpu_pkg::PH_CHAN;
      row_q       <= 8'd0;
      cur_q       <= '0;
      done_q      <= 1'b0;
      work_q      <= tpu_pkg::REC_RESET;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_a) begin
        a_valid_q <= head_valid_i;
      end
      if (fire) begin
        phase_q <= phase_d;
        row_q   <= row_d;
        cur_q   <= cur_d;
        done_q  <= done_d;
        work_q  <= work_d;
        if (a_item_q.start) begin
          valid_q <= '0;
        end else if (mem_we) begin
          valid_q[cur_q] <= 1'b1;
        end
      end
      if (fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_pop_o) begin
      a_item_q <= head_item_i;
      a_chan_q <= head_chan_i;
      rd_q     <= mem_q[head_chan_i];
    end
    if (fire && mem_we) begin
      mem_q[cur_q] <= work_d;
    end
    if (fire && res_valid) begin
      out_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  a_marker_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && marker |=> done_q)
    else $error("end marker did not leave the parser done");

  a_done_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && done_q && !a_item_q.start |-> !res_valid)
    else $error("byte after the end of the pattern produced a result");

  a_start_clears_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && a_item_q.start |=> valid_q == '0)
    else $error("pattern start left channel rows marked as written");

  a_result_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_valid |=> out_valid_q)
    else $error("result of an executed byte was not registered");

endmodule
